// ===== src/mttl_pkg.sv =====
// Shared constants and types for the measured table trilinear lookup.
// Used by mttl_mul, mttl_split and the top level; depends on nothing.
package mttl_pkg;

    localparam int DATA_W      = 32;
    localparam int ANGLE_W     = 16;
    localparam int ADDR_W      = 16;
    localparam int TABLE_DEPTH = 65536;
    localparam int LANES       = 3;
    localparam int MUL_X_W     = DATA_W + 1;

    localparam int ZEN_CFG_W   = 6;
    localparam int AZ_CFG_W    = 7;
    localparam int CFG_DATA_W  = 7;
    localparam int CFG_INDEX_W = 2;

    localparam logic [CFG_INDEX_W-1:0] CFG_ZENITH  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_AZIMUTH = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_KIND    = 2'd2;

    localparam logic CMD_WRITE   = 1'b0;
    localparam logic CMD_QUERY   = 1'b1;
    localparam logic KIND_SCALAR = 1'b0;

    localparam int DEF_MAX_ZENITH    = 32;
    localparam int DEF_MAX_AZIMUTH   = 64;
    localparam int DEF_FRACTION_BITS = 16;

    typedef logic [DATA_W-1:0] word_t;

endpackage

// ===== src/mttl_ram.sv =====
// Generic single-port RAM with registered read data.
// Stand-alone; no package dependency.
module mttl_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 65536
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata_reg <= mem[addr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== src/mttl_mul.sv =====
// Shared three-lane signed-by-unsigned multiplier with registered products.
// Depends on mttl_pkg for lane count and operand width.
module mttl_mul #(
    parameter int Y_W = 16,
    localparam int P_W = mttl_pkg::MUL_X_W + Y_W + 1
) (
    input  logic                          clk,
    input  logic [mttl_pkg::MUL_X_W-1:0]  x    [mttl_pkg::LANES],
    input  logic [Y_W-1:0]                y,
    output logic signed [P_W-1:0]         prod [mttl_pkg::LANES]
);

    logic signed [P_W-1:0] prod_reg [mttl_pkg::LANES];

    always_ff @(posedge clk)
    begin
        for (int l = 0; l < mttl_pkg::LANES; l++)
        begin
            prod_reg[l] <= $signed(x[l]) * $signed({1'b0, y});
        end
    end

    assign prod = prod_reg;

endmodule

// ===== src/mttl_split.sv =====
// Axis split: scaled angle to lower cell index, step flag and fraction.
// Depends on mttl_pkg for the angle width.
module mttl_split #(
    parameter int CW = 7,
    parameter int FB = 16,
    localparam int SPLIT_W = mttl_pkg::ANGLE_W + CW
) (
    input  logic [SPLIT_W-1:0] scaled,
    input  logic [CW-1:0]      n,
    output logic [CW-1:0]      lo,
    output logic               step,
    output logic [FB-1:0]      frac
);

    localparam int TW = CW + FB;

    logic [SPLIT_W+FB-1:0] wide;
    logic [TW-1:0]         t;
    logic [TW-1:0]         half;
    logic [TW-1:0]         top;
    logic [TW-1:0]         shifted;
    logic [TW-1:0]         clamped;

    always_comb
    begin
        wide    = {scaled, {FB{1'b0}}};
        t       = wide[SPLIT_W+FB-1:mttl_pkg::ANGLE_W];
        half    = TW'(1) << (FB - 1);
        top     = {n - CW'(1), {FB{1'b0}}};
        shifted = (t < half) ? '0 : t - half;
        clamped = (shifted > top) ? top : shifted;
        lo      = clamped[TW-1:FB];
        frac    = clamped[FB-1:0];
        step    = ({1'b0, lo} + (CW+1)'(1)) < {1'b0, n};
    end

endmodule

// ===== src/measured_table_trilinear_lookup.sv =====
// Top level: measured three-axis table with cell-centred trilinear lookup.
// Depends on mttl_pkg, mttl_ram, mttl_mul and mttl_split.
//
//   channel   handshake                 payload
//   input     in_valid / in_ready       cmd, entry_index, value_*, *_angle
//   output    out_valid / out_ready     result_r, result_g, result_b
//   config    cfg_we                    cfg_index, cfg_data
//
// A write transaction goes straight into the table. A query runs from acceptance to
// out_valid through 7 setup steps, 8 reads from the single table port and the blend
// steps on the one shared multiplier, then loads the output register.
// An empty table skips setup, fetch and blend and answers zero.
// Reset clears the control state; the datapath registers and the table contents are not cleared.
// A result waits in the output register; the next transaction is taken meanwhile.
module measured_table_trilinear_lookup #(
    parameter int MAX_ZENITH    = mttl_pkg::DEF_MAX_ZENITH,
    parameter int MAX_AZIMUTH   = mttl_pkg::DEF_MAX_AZIMUTH,
    parameter int FRACTION_BITS = mttl_pkg::DEF_FRACTION_BITS
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [mttl_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [mttl_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic                               cmd,
    input  logic [mttl_pkg::ADDR_W-1:0]        entry_index,
    input  logic signed [mttl_pkg::DATA_W-1:0] value_r,
    input  logic signed [mttl_pkg::DATA_W-1:0] value_g,
    input  logic signed [mttl_pkg::DATA_W-1:0] value_b,
    input  logic [mttl_pkg::ANGLE_W-1:0]       outgoing_angle,
    input  logic [mttl_pkg::ANGLE_W-1:0]       incoming_angle,
    input  logic [mttl_pkg::ANGLE_W-1:0]       azimuth_angle,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic signed [mttl_pkg::DATA_W-1:0] result_r,
    output logic signed [mttl_pkg::DATA_W-1:0] result_g,
    output logic signed [mttl_pkg::DATA_W-1:0] result_b
);

    localparam int MAX_CELLS = (MAX_ZENITH > MAX_AZIMUTH) ? MAX_ZENITH : MAX_AZIMUTH;
    localparam int CW        = $clog2(MAX_CELLS + 1);
    localparam int FB        = FRACTION_BITS;
    localparam int YW        = (FB > CW) ? FB : CW;
    localparam int PW        = mttl_pkg::MUL_X_W + YW + 1;
    localparam int SPLIT_W   = mttl_pkg::ANGLE_W + CW;
    localparam int QD        = 8;
    localparam int QI        = $clog2(QD);
    localparam int QW        = $clog2(QD + 1);
    localparam int AW        = mttl_pkg::ADDR_W;
    localparam int DW        = mttl_pkg::DATA_W;
    localparam int LN        = mttl_pkg::LANES;
    localparam int XW        = mttl_pkg::MUL_X_W;

    localparam logic [2:0] ST_OUT_SCALE = 3'd0;
    localparam logic [2:0] ST_IN_SCALE  = 3'd1;
    localparam logic [2:0] ST_AZ_SCALE  = 3'd2;
    localparam logic [2:0] ST_ROW_BASE  = 3'd3;
    localparam logic [2:0] ST_ROW_MUL   = 3'd4;
    localparam logic [2:0] ST_CELL_AREA = 3'd5;
    localparam logic [2:0] ST_ROWS      = 3'd6;

    localparam logic [2:0] LERP_AZ_END = 3'd4;
    localparam logic [2:0] LERP_IN_END = 3'd6;
    localparam logic [2:0] LERP_LAST   = 3'd6;
    localparam logic [2:0] LERP_COUNT  = 3'd7;
    localparam logic [2:0] FETCH_LAST  = 3'(QD - 1);

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_SETUP = 5'b00010,
        ST_FETCH = 5'b00100,
        ST_BLEND = 5'b01000,
        ST_DONE  = 5'b10000
    } state_t;

    state_t state_reg, state_next;
    logic [2:0] cnt_reg, cnt_next;
    logic [mttl_pkg::ZEN_CFG_W-1:0] zen_reg;
    logic [mttl_pkg::AZ_CFG_W-1:0]  az_reg;
    logic kind_reg;
    logic rd_valid_reg;
    logic lerp_v_reg;
    logic [QW-1:0] qn_reg, qn_next;
    logic out_valid_reg, out_valid_next;

    logic [mttl_pkg::ANGLE_W-1:0] ang_o_reg, ang_i_reg, ang_a_reg;
    logic [CW-1:0] o_lo_reg, i_lo_reg, p_lo_reg;
    logic o_step_reg, i_step_reg, p_step_reg;
    logic [FB-1:0] o_frac_reg, i_frac_reg, p_frac_reg;
    logic [AW-1:0] rll_reg;
    logic [AW-1:0] row_reg [4];
    mttl_pkg::word_t q_reg  [LN][QD];
    mttl_pkg::word_t q_next [LN][QD];
    logic [2:0] lerp_idx_reg;
    mttl_pkg::word_t lerp_a_reg [LN];
    mttl_pkg::word_t res_reg [LN];
    mttl_pkg::word_t out_r_reg, out_g_reg, out_b_reg;

    logic accept, accept_query, empty_table, issue, final_done, load_out, push;
    logic [CW-1:0] z_sat, a_sat, split_n, split_lo;
    logic split_step;
    logic [FB-1:0] split_frac, frac_sel;
    logic [XW-1:0] mul_x [LN];
    logic [YW-1:0] mul_y;
    logic signed [PW-1:0] prod [LN];
    logic signed [PW-1:0] shifted [LN];
    mttl_pkg::word_t res_val [LN];
    mttl_pkg::word_t push_val [LN];
    mttl_pkg::word_t rdata [LN];
    mttl_pkg::word_t wdata [LN];
    logic [AW-1:0] fetch_addr, ram_addr, a_ext, za, row_lh, row_hl, row_hh;
    logic [QW-1:0] n_after_pop;
    logic ram_we;

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            zen_reg  <= '0;
            az_reg   <= '0;
            kind_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                mttl_pkg::CFG_ZENITH:  zen_reg  <= cfg_data[mttl_pkg::ZEN_CFG_W-1:0];
                mttl_pkg::CFG_AZIMUTH: az_reg   <= cfg_data[mttl_pkg::AZ_CFG_W-1:0];
                mttl_pkg::CFG_KIND:    kind_reg <= cfg_data[0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        z_sat = (int'(zen_reg) > MAX_ZENITH) ? CW'(MAX_ZENITH) : CW'(zen_reg);
        a_sat = (int'(az_reg) > MAX_AZIMUTH) ? CW'(MAX_AZIMUTH) : CW'(az_reg);
    end

    assign in_ready     = (state_reg == ST_IDLE);
    assign accept       = in_valid && in_ready;
    assign accept_query = accept && (cmd == mttl_pkg::CMD_QUERY);
    assign empty_table  = (z_sat == '0) || (a_sat == '0);
    assign ram_we       = accept && (cmd == mttl_pkg::CMD_WRITE);

    // table memories
    assign fetch_addr = row_reg[cnt_reg[2:1]] + AW'(p_lo_reg)
                        + AW'(cnt_reg[0] & p_step_reg);
    assign ram_addr   = ram_we ? entry_index : fetch_addr;
    assign wdata[0]   = value_r;
    assign wdata[1]   = value_g;
    assign wdata[2]   = value_b;

    for (genvar l = 0; l < LN; l++)
    begin : g_table
        mttl_ram #(
            .WIDTH (DW),
            .DEPTH (mttl_pkg::TABLE_DEPTH)
        ) u_ram (
            .clk   (clk),
            .we    (ram_we),
            .addr  (ram_addr),
            .wdata (wdata[l]),
            .rdata (rdata[l])
        );
    end

    // shared multiplier operands
    always_comb
    begin
        if (cnt_reg < LERP_AZ_END)
        begin
            frac_sel = p_frac_reg;
        end
        else if (cnt_reg < LERP_IN_END)
        begin
            frac_sel = i_frac_reg;
        end
        else
        begin
            frac_sel = o_frac_reg;
        end
        for (int l = 0; l < LN; l++)
        begin
            mul_x[l] = {q_reg[l][1][DW-1], q_reg[l][1]} - {q_reg[l][0][DW-1], q_reg[l][0]};
        end
        mul_y = YW'(frac_sel);
        if (state_reg == ST_SETUP)
        begin
            unique case (cnt_reg)
                ST_OUT_SCALE:
                begin
                    mul_x[0] = XW'(ang_o_reg);
                    mul_y    = YW'(z_sat);
                end
                ST_IN_SCALE:
                begin
                    mul_x[0] = XW'(ang_i_reg);
                    mul_y    = YW'(z_sat);
                end
                ST_AZ_SCALE:
                begin
                    mul_x[0] = XW'(ang_a_reg);
                    mul_y    = YW'(a_sat);
                end
                ST_ROW_BASE:
                begin
                    mul_x[0] = XW'(o_lo_reg);
                    mul_y    = YW'(z_sat);
                end
                ST_ROW_MUL:
                begin
                    mul_x[0] = XW'(prod[0][AW-1:0] + AW'(i_lo_reg));
                    mul_y    = YW'(a_sat);
                end
                default:
                begin
                    mul_x[0] = XW'(z_sat);
                    mul_y    = YW'(a_sat);
                end
            endcase
        end
    end

    mttl_mul #(
        .Y_W (YW)
    ) u_mul (
        .clk  (clk),
        .x    (mul_x),
        .y    (mul_y),
        .prod (prod)
    );

    assign split_n = (cnt_reg == ST_ROW_BASE) ? a_sat : z_sat;

    mttl_split #(
        .CW (CW),
        .FB (FB)
    ) u_split (
        .scaled (prod[0][SPLIT_W-1:0]),
        .n      (split_n),
        .lo     (split_lo),
        .step   (split_step),
        .frac   (split_frac)
    );

    // row bases
    always_comb
    begin
        a_ext  = AW'(a_sat);
        za     = prod[0][AW-1:0];
        row_lh = rll_reg + (i_step_reg ? a_ext : '0);
        row_hl = rll_reg + (o_step_reg ? za : '0);
        row_hh = row_hl + (i_step_reg ? a_ext : '0);
    end

    // blend completion and queue
    always_comb
    begin
        for (int l = 0; l < LN; l++)
        begin
            shifted[l]  = prod[l] >>> FB;
            res_val[l]  = lerp_a_reg[l] + shifted[l][DW-1:0];
            push_val[l] = rd_valid_reg ? rdata[l] : res_val[l];
        end
    end

    assign issue      = (state_reg == ST_BLEND) && (cnt_reg != LERP_COUNT)
                        && (qn_reg >= QW'(2));
    assign final_done = lerp_v_reg && (lerp_idx_reg == LERP_LAST);
    assign push       = rd_valid_reg || (lerp_v_reg && (lerp_idx_reg != LERP_LAST));
    assign load_out   = (state_reg == ST_DONE) && (!out_valid_reg || out_ready);

    always_comb
    begin
        q_next      = q_reg;
        n_after_pop = issue ? qn_reg - QW'(2) : qn_reg;
        if (issue)
        begin
            for (int l = 0; l < LN; l++)
            begin
                for (int i = 0; i < QD - 2; i++)
                begin
                    q_next[l][i] = q_reg[l][i+2];
                end
            end
        end
        if (push)
        begin
            for (int l = 0; l < LN; l++)
            begin
                q_next[l][n_after_pop[QI-1:0]] = push_val[l];
            end
            qn_next = n_after_pop + QW'(1);
        end
        else
        begin
            qn_next = n_after_pop;
        end
        if (accept_query)
        begin
            qn_next = '0;
        end
    end

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept_query)
                begin
                    cnt_next   = '0;
                    state_next = empty_table ? ST_DONE : ST_SETUP;
                end
            end
            ST_SETUP:
            begin
                cnt_next = cnt_reg + 3'd1;
                if (cnt_reg == ST_ROWS)
                begin
                    cnt_next   = '0;
                    state_next = ST_FETCH;
                end
            end
            ST_FETCH:
            begin
                cnt_next = cnt_reg + 3'd1;
                if (cnt_reg == FETCH_LAST)
                begin
                    cnt_next   = '0;
                    state_next = ST_BLEND;
                end
            end
            ST_BLEND:
            begin
                if (issue)
                begin
                    cnt_next = cnt_reg + 3'd1;
                end
                if (final_done)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (load_out)
                begin
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            rd_valid_reg  <= 1'b0;
            lerp_v_reg    <= 1'b0;
            qn_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            rd_valid_reg  <= (state_reg == ST_FETCH);
            lerp_v_reg    <= issue;
            qn_reg        <= qn_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
        if (accept_query)
        begin
            ang_o_reg <= outgoing_angle;
            ang_i_reg <= incoming_angle;
            ang_a_reg <= azimuth_angle;
            for (int l = 0; l < LN; l++)
            begin
                res_reg[l] <= '0;
            end
        end
        if (state_reg == ST_SETUP)
        begin
            unique case (cnt_reg)
                ST_IN_SCALE:
                begin
                    o_lo_reg   <= split_lo;
                    o_step_reg <= split_step;
                    o_frac_reg <= split_frac;
                end
                ST_AZ_SCALE:
                begin
                    i_lo_reg   <= split_lo;
                    i_step_reg <= split_step;
                    i_frac_reg <= split_frac;
                end
                ST_ROW_BASE:
                begin
                    p_lo_reg   <= split_lo;
                    p_step_reg <= split_step;
                    p_frac_reg <= split_frac;
                end
                ST_CELL_AREA:
                begin
                    rll_reg <= prod[0][AW-1:0];
                end
                ST_ROWS:
                begin
                    row_reg[0] <= rll_reg;
                    row_reg[1] <= row_lh;
                    row_reg[2] <= row_hl;
                    row_reg[3] <= row_hh;
                end
                default: ;
            endcase
        end
        if (issue)
        begin
            lerp_idx_reg <= cnt_reg;
            for (int l = 0; l < LN; l++)
            begin
                lerp_a_reg[l] <= q_reg[l][0];
            end
        end
        if (final_done)
        begin
            res_reg <= res_val;
        end
        if (load_out)
        begin
            out_r_reg <= res_reg[0];
            out_g_reg <= (kind_reg == mttl_pkg::KIND_SCALAR) ? res_reg[0] : res_reg[1];
            out_b_reg <= (kind_reg == mttl_pkg::KIND_SCALAR) ? res_reg[0] : res_reg[2];
        end
    end

    assign out_valid = out_valid_reg;
    assign result_r  = out_r_reg;
    assign result_g  = out_g_reg;
    assign result_b  = out_b_reg;

`ifndef ASSERT_OFF
    a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
        qn_reg <= QW'(QD))
        else $error("blend queue overfilled");

    a_corners_in: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_BLEND && $past(state_reg) == ST_FETCH) |-> qn_reg == QW'(QD - 1))
        else $error("corner values missing at blend start");

    a_final_in_blend: assert property (@(posedge clk) disable iff (!rst_n)
        (lerp_v_reg && lerp_idx_reg == LERP_LAST) |-> state_reg == ST_BLEND)
        else $error("final blend outside blend phase");

    a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg) == ST_DONE)
        else $error("result presented without a finished query");
`endif

endmodule

// ===== tb/tb_top.sv =====
// Self-checking testbench for measured_table_trilinear_lookup: table writes and
// trilinear lookups under a series of register settings, checked against an in-bench predictor.
// Depends on mttl_pkg and the RTL of the block only.
module tb_top;

    import mttl_pkg::*;

    localparam int      MAX_Z         = DEF_MAX_ZENITH;
    localparam int      MAX_A         = DEF_MAX_AZIMUTH;
    localparam int      FRAC_BITS     = DEF_FRACTION_BITS;
    localparam int      IDLE_PCT      = 9;
    localparam int      SETTLE_CYCLES = 40;
    localparam int      DRAIN_LIMIT   = 5000;
    localparam int      HOLD_CYCLES   = 300;
    localparam int      ITEM_TARGET   = 500;
    localparam int      N_SETTINGS    = 8;
    localparam longint  RUN_LIMIT     = 64'd20_000_000;
    localparam int      CH_R          = 0;
    localparam int      CH_G          = 1;
    localparam int      CH_B          = 2;

    typedef struct {
        logic                     cmd;
        logic [ADDR_W-1:0]        idx;
        logic signed [DATA_W-1:0] vr, vg, vb;
        logic [ANGLE_W-1:0]       ao, ai, ap;
    } lookup_xact_t;

    typedef struct {
        logic signed [DATA_W-1:0] r, g, b;
    } rgb_t;

    typedef struct {
        int unsigned lo, hi;
        longint      frac;
    } axis_cut_t;

    logic                     clk;
    logic                     rst_n;
    logic                     cfg_we;
    logic [CFG_INDEX_W-1:0]   cfg_index;
    logic [CFG_DATA_W-1:0]    cfg_data;
    logic                     in_valid;
    logic                     in_ready;
    logic                     cmd;
    logic [ADDR_W-1:0]        entry_index;
    logic signed [DATA_W-1:0] value_r, value_g, value_b;
    logic [ANGLE_W-1:0]       outgoing_angle, incoming_angle, azimuth_angle;
    logic                     out_valid;
    logic                     out_ready;
    logic signed [DATA_W-1:0] result_r, result_g, result_b;

    logic signed [DATA_W-1:0] entry_r [int unsigned];
    logic signed [DATA_W-1:0] entry_g [int unsigned];
    logic signed [DATA_W-1:0] entry_b [int unsigned];
    int unsigned              zen_cfg;
    int unsigned              az_cfg;
    logic                     kind_cfg;

    rgb_t pending_rgb [$];
    int   mismatches;
    int   n_writes;
    int   n_lookups;
    int   n_settings;
    int   hold_left;
    bit   no_gaps;

    measured_table_trilinear_lookup i_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .cmd            (cmd),
        .entry_index    (entry_index),
        .value_r        (value_r),
        .value_g        (value_g),
        .value_b        (value_b),
        .outgoing_angle (outgoing_angle),
        .incoming_angle (incoming_angle),
        .azimuth_angle  (azimuth_angle),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .result_r       (result_r),
        .result_g       (result_g),
        .result_b       (result_b)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #10 clk = ~clk;

    initial
    begin
        #(RUN_LIMIT);
        $display("CHECKS FAILED");
        $finish;
    end

    task automatic report_mismatch(input string msg);
        $display("MISMATCH @%0t: %s", $time, msg);
        mismatches++;
    endtask

    // ---------------- predictor ----------------

    function automatic int unsigned eff_zenith();
        return (zen_cfg > MAX_Z) ? MAX_Z : zen_cfg;
    endfunction

    function automatic int unsigned eff_azimuth();
        return (az_cfg > MAX_A) ? MAX_A : az_cfg;
    endfunction

    function automatic axis_cut_t cut_axis(input logic [ANGLE_W-1:0] angle,
                                           input int unsigned n);
        axis_cut_t       c;
        longint unsigned half;
        longint unsigned top;
        longint unsigned t;
        half   = 64'd1 << (FRAC_BITS - 1);
        top    = longint'(n - 1) << FRAC_BITS;
        t      = ((longint'(angle) * longint'(n)) << FRAC_BITS) >> ANGLE_W;
        t      = (t < half) ? 64'd0 : t - half;
        if (t > top)
            t = top;
        c.lo   = int'(t >> FRAC_BITS);
        c.hi   = (c.lo + 1 < n) ? c.lo + 1 : n - 1;
        c.frac = longint'(t & ((64'd1 << FRAC_BITS) - 1));
        return c;
    endfunction

    function automatic int unsigned entry_addr(input int unsigned o, i, p, z, a);
        return ((o * z + i) * a + p) & 32'hFFFF;
    endfunction

    function automatic longint read_entry(input int ch, input int unsigned addr);
        case (ch)
            CH_R:    return longint'(entry_r[addr]);
            CH_G:    return longint'(entry_g[addr]);
            default: return longint'(entry_b[addr]);
        endcase
    endfunction

    // floor((b - a) * f / 2^FB) added to a
    function automatic longint lerp_fx(input longint a, b, f);
        longint p;
        p = (b - a) * f;
        return a + (p >>> FRAC_BITS);
    endfunction

    function automatic longint blend_channel(input int ch, input axis_cut_t co, ci, cp,
                                             input int unsigned z, a);
        longint v00, v01, v10, v11;
        v00 = lerp_fx(read_entry(ch, entry_addr(co.lo, ci.lo, cp.lo, z, a)),
                      read_entry(ch, entry_addr(co.lo, ci.lo, cp.hi, z, a)), cp.frac);
        v01 = lerp_fx(read_entry(ch, entry_addr(co.lo, ci.hi, cp.lo, z, a)),
                      read_entry(ch, entry_addr(co.lo, ci.hi, cp.hi, z, a)), cp.frac);
        v10 = lerp_fx(read_entry(ch, entry_addr(co.hi, ci.lo, cp.lo, z, a)),
                      read_entry(ch, entry_addr(co.hi, ci.lo, cp.hi, z, a)), cp.frac);
        v11 = lerp_fx(read_entry(ch, entry_addr(co.hi, ci.hi, cp.lo, z, a)),
                      read_entry(ch, entry_addr(co.hi, ci.hi, cp.hi, z, a)), cp.frac);
        return lerp_fx(lerp_fx(v00, v01, ci.frac), lerp_fx(v10, v11, ci.frac), co.frac);
    endfunction

    function automatic rgb_t predict_rgb(input logic [ANGLE_W-1:0] ao, ai, ap);
        rgb_t        res;
        int unsigned z;
        int unsigned a;
        axis_cut_t   co, ci, cp;
        z = eff_zenith();
        a = eff_azimuth();
        if (z == 0 || a == 0)
        begin
            res.r = '0;
            res.g = '0;
            res.b = '0;
            return res;
        end
        co    = cut_axis(ao, z);
        ci    = cut_axis(ai, z);
        cp    = cut_axis(ap, a);
        res.r = DATA_W'(blend_channel(CH_R, co, ci, cp, z, a));
        if (kind_cfg == KIND_SCALAR)
        begin
            res.g = res.r;
            res.b = res.r;
        end
        else
        begin
            res.g = DATA_W'(blend_channel(CH_G, co, ci, cp, z, a));
            res.b = DATA_W'(blend_channel(CH_B, co, ci, cp, z, a));
        end
        return res;
    endfunction

    // ---------------- drivers ----------------

    // Called and returns at a falling edge; valid stays high between back-to-back items.
    task automatic send_item(input lookup_xact_t x);
        while (!no_gaps && $urandom_range(0, 99) < IDLE_PCT)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        cmd            <= x.cmd;
        entry_index    <= x.idx;
        value_r        <= x.vr;
        value_g        <= x.vg;
        value_b        <= x.vb;
        outgoing_angle <= x.ao;
        incoming_angle <= x.ai;
        azimuth_angle  <= x.ap;
        in_valid       <= 1'b1;
        do
            @(posedge clk);
        while (!in_ready);
        if (x.cmd == CMD_WRITE)
        begin
            entry_r[x.idx] = x.vr;
            entry_g[x.idx] = x.vg;
            entry_b[x.idx] = x.vb;
            n_writes++;
        end
        else
        begin
            pending_rgb.push_back(predict_rgb(x.ao, x.ai, x.ap));
            n_lookups++;
        end
        @(negedge clk);
    endtask

    task automatic send_write(input int unsigned addr, input logic [DATA_W-1:0] r, g, b);
        lookup_xact_t x;
        x.cmd = CMD_WRITE;
        x.idx = ADDR_W'(addr);
        x.vr  = r;
        x.vg  = g;
        x.vb  = b;
        x.ao  = ANGLE_W'($urandom);
        x.ai  = ANGLE_W'($urandom);
        x.ap  = ANGLE_W'($urandom);
        send_item(x);
    endtask

    // Writes any of the eight neighbouring entries not yet stored, then issues the lookup.
    task automatic send_lookup(input logic [ANGLE_W-1:0] ao, ai, ap);
        lookup_xact_t x;
        axis_cut_t    co, ci, cp;
        int unsigned  z, a, addr;
        int unsigned  ol [2];
        int unsigned  il [2];
        int unsigned  pl [2];
        z = eff_zenith();
        a = eff_azimuth();
        if (z != 0 && a != 0)
        begin
            co = cut_axis(ao, z);
            ci = cut_axis(ai, z);
            cp = cut_axis(ap, a);
            ol = '{co.lo, co.hi};
            il = '{ci.lo, ci.hi};
            pl = '{cp.lo, cp.hi};
            for (int m = 0; m < 8; m++)
            begin
                addr = entry_addr(ol[m[2]], il[m[1]], pl[m[0]], z, a);
                if (!entry_r.exists(addr))
                    send_write(addr, $urandom, $urandom, $urandom);
            end
        end
        x.cmd = CMD_QUERY;
        x.idx = ADDR_W'($urandom);
        x.vr  = $urandom;
        x.vg  = $urandom;
        x.vb  = $urandom;
        x.ao  = ao;
        x.ai  = ai;
        x.ap  = ap;
        send_item(x);
    endtask

    task automatic drain(input bit settle);
        int guard;
        in_valid <= 1'b0;
        guard = 0;
        while (pending_rgb.size() != 0 && guard < DRAIN_LIMIT)
        begin
            @(negedge clk);
            guard++;
        end
        if (pending_rgb.size() != 0)
        begin
            report_mismatch($sformatf("%0d expected results never arrived",
                                      pending_rgb.size()));
            pending_rgb.delete();
        end
        if (settle)
            repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic set_config(input int unsigned z, a, input logic k);
        drain(1'b1);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_ZENITH;
        cfg_data  <= CFG_DATA_W'(z);
        @(negedge clk);
        cfg_index <= CFG_AZIMUTH;
        cfg_data  <= CFG_DATA_W'(a);
        @(negedge clk);
        cfg_index <= CFG_KIND;
        cfg_data  <= CFG_DATA_W'(k);
        @(negedge clk);
        cfg_we    <= 1'b0;
        zen_cfg   = z % 64;
        az_cfg    = a % 128;
        kind_cfg  = k;
        n_settings++;
    endtask

    function automatic logic [ANGLE_W-1:0] pick_angle();
        case ($urandom_range(0, 19))
            0:       return '0;
            1:       return '1;
            2:       return 16'h8000;
            3:       return 16'h7FFF;
            default: return ANGLE_W'($urandom);
        endcase
    endfunction

    // ---------------- result side ----------------

    initial
    begin
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_left > 0)
            begin
                out_ready <= 1'b0;
                hold_left--;
            end
            else
                out_ready <= no_gaps || ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    always @(posedge clk)
    begin : check_result
        rgb_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_rgb.size() == 0)
                report_mismatch($sformatf("unexpected result %h %h %h",
                                          result_r, result_g, result_b));
            else
            begin
                want = pending_rgb.pop_front();
                if (result_r !== want.r)
                    report_mismatch($sformatf("result_r %h, want %h", result_r, want.r));
                if (result_g !== want.g)
                    report_mismatch($sformatf("result_g %h, want %h", result_g, want.g));
                if (result_b !== want.b)
                    report_mismatch($sformatf("result_b %h, want %h", result_b, want.b));
            end
        end
    end

    // ---------------- tests ----------------

    task automatic test_empty_table();
        send_write(0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000);
        send_write(16'hFFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
        send_lookup('0, '0, '0);
        send_lookup('1, '1, '1);
        send_lookup(16'h8000, 16'h1234, 16'hFEDC);
    endtask

    task automatic test_single_cell();
        set_config(1, 1, 1'b1);
        send_lookup('0, '0, '0);
        send_lookup('1, '1, '1);
        send_lookup(16'h8000, 16'h7FFF, 16'h4000);
    endtask

    task automatic test_corner_blends();
        set_config(2, 2, 1'b1);
        for (int e = 0; e < 8; e++)
            send_write(e, e[0] ? 32'h8000_0000 : 32'h7FFF_FFFF,
                       e[0] ? 32'h7FFF_FFFF : 32'h8000_0000, $urandom);
        send_lookup('0, '0, '0);
        send_lookup('1, '1, '1);
        send_lookup(16'h8000, 16'h4000, 16'hC000);
    endtask

    task automatic test_scalar_mode();
        set_config(3, 2, KIND_SCALAR);
        send_lookup(16'h5555, 16'hAAAA, 16'h9000);
    endtask

    task automatic test_oversized_counts();
        set_config(63, 127, 1'b1);
        send_lookup('1, 16'h0100, '1);
    endtask

    task automatic test_zero_axis();
        set_config(0, 7, 1'b1);
        send_lookup(16'h3333, 16'hCCCC, 16'h8000);
        set_config(9, 0, KIND_SCALAR);
        send_lookup('1, '0, '1);
    endtask

    task automatic test_backpressure();
        set_config(3, 4, 1'b1);
        for (int e = 0; e < 36; e++)
            if (!entry_r.exists(e))
                send_write(e, $urandom, $urandom, $urandom);
        drain(1'b0);
        hold_left = HOLD_CYCLES;
        repeat (20) send_lookup(ANGLE_W'($urandom), ANGLE_W'($urandom), ANGLE_W'($urandom));
        // sender waits here until every lookup has been answered
        drain(1'b0);
        repeat (10) send_lookup(ANGLE_W'($urandom), ANGLE_W'($urandom), ANGLE_W'($urandom));
    endtask

    // The remaining item budget is shared out over the settings, neighbour writes included.
    task automatic test_random_settings();
        int unsigned z, a;
        int          pick;
        int          start;
        int          share;
        for (int s = 0; s < N_SETTINGS; s++)
        begin
            case ($urandom_range(0, 19))
                0:       z = 0;
                1, 2:    z = $urandom_range(5, 63);
                3:       z = 32;
                default: z = $urandom_range(1, 4);
            endcase
            case ($urandom_range(0, 19))
                0:       a = 0;
                1, 2:    a = $urandom_range(7, 127);
                3:       a = 64;
                default: a = $urandom_range(1, 6);
            endcase
            set_config(z, a, $urandom_range(0, 1));
            no_gaps = (s == 3);
            start   = n_writes + n_lookups;
            share   = (ITEM_TARGET - start) / (N_SETTINGS - s);
            while (n_writes + n_lookups - start < share)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 80)
                    send_lookup(pick_angle(), pick_angle(), pick_angle());
                else
                    send_write($urandom_range(0, 65535), $urandom, $urandom, $urandom);
            end
            no_gaps = 1'b0;
        end
    endtask

    initial
    begin
        rst_n          = 1'b0;
        cfg_we         = 1'b0;
        cfg_index      = CFG_ZENITH;
        cfg_data       = '0;
        in_valid       = 1'b0;
        cmd            = CMD_WRITE;
        entry_index    = '0;
        value_r        = '0;
        value_g        = '0;
        value_b        = '0;
        outgoing_angle = '0;
        incoming_angle = '0;
        azimuth_angle  = '0;
        zen_cfg        = 0;
        az_cfg         = 0;
        kind_cfg       = KIND_SCALAR;
        mismatches     = 0;
        n_writes       = 0;
        n_lookups      = 0;
        n_settings     = 0;
        hold_left      = 0;
        no_gaps        = 1'b0;
        repeat (11) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_empty_table();
        test_single_cell();
        test_corner_blends();
        test_scalar_mode();
        test_oversized_counts();
        test_zero_axis();
        test_backpressure();
        test_random_settings();
        drain(1'b1);

        $display("Run covered %0d table writes and %0d lookups over %0d register settings,",
                 n_writes, n_lookups, n_settings);
        $display("with empty, scalar, saturated-size and output-stall phases.");
        if (mismatches == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

// ===== filelist.f =====
src/mttl_pkg.sv
src/mttl_ram.sv
src/mttl_mul.sv
src/mttl_split.sv
src/measured_table_trilinear_lookup.sv
tb/tb_top.sv
